// File: hdl/csfw_pkg.sv
// ----------------------------------------------------------------------------
// csfw_pkg
// Types and codes shared by the counting semaphore with a waiter queue.
// ----------------------------------------------------------------------------
package csfw_pkg;

  localparam logic [1:0] FN_TRY = 2'd0;
  localparam logic [1:0] FN_ACQ = 2'd1;
  localparam logic [1:0] FN_REL = 2'd2;

  localparam logic [2:0] ST_GRANTED   = 3'd0;
  localparam logic [2:0] ST_REFUSED   = 3'd1;
  localparam logic [2:0] ST_QUEUED    = 3'd2;
  localparam logic [2:0] ST_PASSED    = 3'd3;
  localparam logic [2:0] ST_RELEASED  = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_UNDERFLOW = 3'd6;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  requester_id;
    logic [15:0] requester_tag;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        notify_valid;
    logic [7:0]  notify_id;
    logic [15:0] notify_tag;
    logic [7:0]  holders_now;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] tag;
  } waiter_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic rsp_free;
  } dp_stat_t;

endpackage

// File: hdl/csfw_ctrl.sv
// ----------------------------------------------------------------------------
// csfw_ctrl
// Sequencer that captures one request and commits it to the datapath.
// ----------------------------------------------------------------------------
module csfw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  csfw_pkg::dp_stat_t stat,
  output csfw_pkg::ctl_cmd_t cmd
);
  import csfw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.commit = stat.rsp_free;
        if (stat.rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/csfw_dpath.sv
// ----------------------------------------------------------------------------
// csfw_dpath
// Holder counter, waiter queue memory and result register.
// ----------------------------------------------------------------------------
module csfw_dpath #(
  parameter int WAIT_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  csfw_pkg::req_t     req,
  input  csfw_pkg::ctl_cmd_t cmd,
  output csfw_pkg::dp_stat_t stat,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output csfw_pkg::rsp_t     rsp
);
  import csfw_pkg::*;

  localparam int PTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int FILL_W = $clog2(WAIT_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(WAIT_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WAIT_DEPTH);

  logic [7:0]        max_holders;
  logic [7:0]        holder_count;
  logic [7:0]        holder_count_next;
  logic [PTR_W-1:0]  wait_head;
  logic [PTR_W-1:0]  wait_tail;
  logic [FILL_W-1:0] wait_fill;
  waiter_t           mem [WAIT_DEPTH];
  waiter_t           head_entry;
  req_t              op;
  rsp_t              rsp_next;
  logic              push;
  logic              pop;
  logic              slot_free;

  assign stat.rsp_free = !rsp_valid || rsp_ready;
  assign slot_free     = holder_count < max_holders;

  always_comb begin
    rsp_next          = '0;
    rsp_next.status   = ST_REFUSED;
    holder_count_next = holder_count;
    push              = 1'b0;
    pop               = 1'b0;
    unique case (op.func)
      FN_TRY: begin
        if (slot_free) begin
          holder_count_next = holder_count + 8'd1;
          rsp_next.status   = ST_GRANTED;
        end
      end
      FN_ACQ: begin
        if (slot_free) begin
          holder_count_next     = holder_count + 8'd1;
          rsp_next.status       = ST_GRANTED;
          rsp_next.notify_valid = 1'b1;
          rsp_next.notify_id    = op.requester_id;
          rsp_next.notify_tag   = op.requester_tag;
        end else if (wait_fill == FILL_FULL) begin
          rsp_next.status = ST_FULL;
        end else begin
          push            = 1'b1;
          rsp_next.status = ST_QUEUED;
        end
      end
      FN_REL: begin
        if (holder_count == 8'd0) begin
          rsp_next.status = ST_UNDERFLOW;
        end else if (holder_count <= max_holders && wait_fill != '0) begin
          pop                   = 1'b1;
          rsp_next.status       = ST_PASSED;
          rsp_next.notify_valid = 1'b1;
          rsp_next.notify_id    = head_entry.id;
          rsp_next.notify_tag   = head_entry.tag;
        end else begin
          holder_count_next = holder_count - 8'd1;
          rsp_next.status   = ST_RELEASED;
        end
      end
      default: begin
        rsp_next.status = ST_REFUSED;
      end
    endcase
    rsp_next.holders_now = holder_count_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= req;
    end
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && push) begin
      mem[wait_tail] <= '{id: op.requester_id, tag: op.requester_tag};
    end
    head_entry <= mem[wait_head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_holders  <= 8'd1;
      holder_count <= '0;
      wait_head    <= '0;
      wait_tail    <= '0;
      wait_fill    <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_holders <= cfg_wdata;
      end
      if (cmd.commit) begin
        holder_count <= holder_count_next;
        rsp_valid    <= 1'b1;
        if (push) begin
          wait_tail <= (wait_tail == PTR_LAST) ? '0 : wait_tail + 1'b1;
          wait_fill <= wait_fill + 1'b1;
        end
        if (pop) begin
          wait_head <= (wait_head == PTR_LAST) ? '0 : wait_head + 1'b1;
          wait_fill <= wait_fill - 1'b1;
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/counting_semaphore_fifo_waiters_core.sv
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_core
// Counting semaphore with a bounded holder count and a FIFO of waiters.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  csfw_pkg::req_t
// rsp      out        rsp_valid / rsp_ready  csfw_pkg::rsp_t
// cfg      in         cfg_we                 cfg_wdata (max_holders)
//
// Each transaction is captured in one state and committed in the next,
// the commit giving the registered waiter queue memory time to present the
// oldest waiter. Reset is synchronous and needs no clearing pass. A result
// waits in the output register while the next transaction is captured; the
// commit stalls only while that register is still held by rsp_ready low.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters_core #(
  parameter int WAIT_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata,
  input  logic           req_valid,
  output logic           req_ready,
  input  csfw_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output csfw_pkg::rsp_t rsp
);
  import csfw_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  csfw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  csfw_dpath #(
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Randomized check of the counting semaphore with a FIFO of waiters.
// ----------------------------------------------------------------------------
// A directed opening walks through underflow, try-acquire, queueing, handoff
// to a waiter, a full waiter queue and a maximum of zero. Random bursts then
// grow and drain the holder count and the waiter queue under several
// max_holders settings. Every accepted request is predicted in the bench and
// each response is compared field by field, with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import csfw_pkg::*;

  localparam int WAIT_DEPTH = 16;
  localparam int LONG_HOLD = 80;
  localparam logic [1:0] FN_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  req_t request_backlog[$];
  rsp_t predicted_rsp[$];

  logic [7:0] holders = 8'd0;
  logic [7:0] max_holders = 8'd1;
  waiter_t waiter_line[$];

  int mismatches = 0;
  int accepted_requests = 0;
  int settings_used = 1;
  int status_seen[8];
  int send_gap = 0;
  int ready_gap = 0;
  bit long_hold_armed = 1'b0;
  bit long_hold_done = 1'b0;

  counting_semaphore_fifo_waiters_core #(
    .WAIT_DEPTH(WAIT_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic rsp_t semaphore_step(req_t r);
    rsp_t o;
    logic slot_free;
    waiter_t w;
    o = '0;
    o.status = ST_REFUSED;
    slot_free = holders < max_holders;
    case (r.func)
      FN_TRY: begin
        if (slot_free) begin
          holders = holders + 8'd1;
          o.status = ST_GRANTED;
        end
      end
      FN_ACQ: begin
        if (slot_free) begin
          holders = holders + 8'd1;
          o.status = ST_GRANTED;
          o.notify_valid = 1'b1;
          o.notify_id = r.requester_id;
          o.notify_tag = r.requester_tag;
        end else if (waiter_line.size() >= WAIT_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          w.id = r.requester_id;
          w.tag = r.requester_tag;
          waiter_line.push_back(w);
          o.status = ST_QUEUED;
        end
      end
      FN_REL: begin
        if (holders == 8'd0) begin
          o.status = ST_UNDERFLOW;
        end else if (holders <= max_holders && waiter_line.size() > 0) begin
          w = waiter_line.pop_front();
          o.status = ST_PASSED;
          o.notify_valid = 1'b1;
          o.notify_id = w.id;
          o.notify_tag = w.tag;
        end else begin
          holders = holders - 8'd1;
          o.status = ST_RELEASED;
        end
      end
      default: begin
      end
    endcase
    o.holders_now = holders;
    status_seen[o.status]++;
    return o;
  endfunction

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
      mismatches++;
    end
  endfunction

  function automatic void compare_response(rsp_t got);
    rsp_t exp;
    if (predicted_rsp.size() == 0) begin
      $error("response with no transaction outstanding: 0x%0h", got);
      mismatches++;
      return;
    end
    exp = predicted_rsp.pop_front();
    check_field("status", exp.status, got.status);
    check_field("notify_valid", exp.notify_valid, got.notify_valid);
    check_field("notify_id", exp.notify_id, got.notify_id);
    check_field("notify_tag", exp.notify_tag, got.notify_tag);
    check_field("holders_now", exp.holders_now, got.holders_now);
  endfunction

  function automatic req_t make_req(logic [1:0] f, logic [7:0] id, logic [15:0] tag);
    req_t r;
    r.func = f;
    r.requester_id = id;
    r.requester_tag = tag;
    return r;
  endfunction

  function automatic req_t random_req(bit grow);
    int pick;
    logic [1:0] f;
    pick = $urandom_range(0, 99);
    if (pick < 5) f = FN_NONE;
    else if (pick < (grow ? 20 : 15)) f = FN_TRY;
    else if (pick < (grow ? 75 : 35)) f = FN_ACQ;
    else f = FN_REL;
    return make_req(f, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
  endfunction

  // Driver: offers one request at a time and predicts it when it is accepted.
  always @(posedge clk) begin
    bit offering;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      offering = req_valid;
      if (req_valid && req_ready) begin
        predicted_rsp.push_back(semaphore_step(req));
        accepted_requests++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_backlog.size() > 0) begin
          req <= request_backlog.pop_front();
          offering = 1'b1;
          send_gap = pick_gap();
        end
      end
      req_valid <= offering;
    end
  end

  // Monitor: checks each response transaction and throttles rsp_ready.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) compare_response(rsp);
      if (long_hold_armed && !long_hold_done) begin
        ready_gap = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (ready_gap > 0) begin
        ready_gap--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
        ready_gap = pick_gap();
      end
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (request_backlog.size() != 0 || req_valid || predicted_rsp.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_max_holders(logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_holders = value;
    settings_used++;
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] plan[8];
    int queued;
    int burst;
    bit grow;
    plan = '{8'd3, 8'd255, 8'd2, 8'd1, 8'd0, 8'd7, 8'd1, 8'd4};
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // With the reset maximum of one: underflow, try-acquire, queue, handoff.
    request_backlog.push_back(make_req(FN_REL, 8'h00, 16'h0000));
    request_backlog.push_back(make_req(FN_TRY, 8'hFF, 16'hFFFF));
    request_backlog.push_back(make_req(FN_TRY, 8'h00, 16'h0000));
    request_backlog.push_back(make_req(FN_ACQ, 8'hA5, 16'h5A5A));
    request_backlog.push_back(make_req(FN_NONE, 8'hFF, 16'hFFFF));
    request_backlog.push_back(make_req(FN_REL, 8'h5A, 16'hA5A5));
    request_backlog.push_back(make_req(FN_REL, 8'h00, 16'h0000));
    request_backlog.push_back(make_req(FN_ACQ, 8'hFF, 16'hFFFF));
    for (int i = 0; i <= WAIT_DEPTH; i++)
      request_backlog.push_back(make_req(FN_ACQ, 8'(i * 17), 16'(16'h1111 * i + 3)));
    wait_idle();

    // A maximum of zero below the current count, with a full waiter queue.
    write_max_holders(8'd0);
    request_backlog.push_back(make_req(FN_REL, 8'h01, 16'h0001));
    request_backlog.push_back(make_req(FN_REL, 8'h02, 16'h0002));
    request_backlog.push_back(make_req(FN_TRY, 8'h03, 16'h0003));
    request_backlog.push_back(make_req(FN_ACQ, 8'h04, 16'h0004));
    wait_idle();

    foreach (plan[p]) begin
      write_max_holders(plan[p]);
      if (p == 1) long_hold_armed = 1'b1;
      queued = 0;
      while (queued < 50) begin
        grow = $urandom_range(0, 1);
        burst = $urandom_range(4, 24);
        for (int i = 0; i < burst && queued < 50; i++) begin
          request_backlog.push_back(random_req(grow));
          queued++;
        end
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    if (predicted_rsp.size() != 0) begin
      $error("%0d responses never arrived", predicted_rsp.size());
      mismatches++;
    end
    $display("Checked %0d requests over %0d max_holders settings, zero and 255 included.",
             accepted_requests, settings_used);
    $display(
      "Granted %0d, refused %0d, queued %0d, passed %0d, released %0d, full %0d, underflow %0d.",
      status_seen[ST_GRANTED], status_seen[ST_REFUSED], status_seen[ST_QUEUED],
      status_seen[ST_PASSED], status_seen[ST_RELEASED], status_seen[ST_FULL],
      status_seen[ST_UNDERFLOW]);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
hdl/csfw_pkg.sv
hdl/csfw_ctrl.sv
hdl/csfw_dpath.sv
hdl/counting_semaphore_fifo_waiters_core.sv
bench/testbench.sv
